### design/dcbd_pkg.sv
// Shared types and constants of the dual CPU bus decoder.
`default_nettype none

package dcbd_pkg;

    localparam int RAM_BYTES = 8192;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIP_ONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_TWO = 1'd1;

    typedef logic [RAM_AW-1:0] t_ram_idx;

    typedef enum logic [2:0] {
        FN_MEM_RD   = 3'd0,
        FN_MEM_WR   = 3'd1,
        FN_PORT_OUT = 3'd2,
        FN_PORT_IN  = 3'd3,
        FN_FETCH    = 3'd4,
        FN_IRQ_ACK  = 3'd5
    } t_func;

    typedef struct packed {
        logic       cpu;
        t_func      func;
        logic [15:0] address;
        logic [7:0] write_data;
        logic [6:0] buttons;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       from_rom;
        logic       nmi_enabled;
        logic       sound_irq_pending;
        logic       custom_background;
        logic [7:0] sound_filter;
    } t_out_word;

    typedef struct packed {
        logic       en;
        logic       we;
        t_ram_idx   idx;
        logic [7:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

### design/dcbd_ram.sv
// Shared work RAM with a post-reset clearing sweep.
`default_nettype none

module dcbd_ram (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dcbd_pkg::t_ram_req i_req,
    output logic [7:0]              o_rdata,
    output logic                    o_ready
);

    localparam dcbd_pkg::t_ram_idx LAST_IDX = dcbd_pkg::RAM_AW'(dcbd_pkg::RAM_BYTES - 1);

    logic [7:0]         r_mem [dcbd_pkg::RAM_BYTES];
    logic [7:0]         r_rdata;
    logic               r_clearing;
    dcbd_pkg::t_ram_idx r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.en && i_req.we) begin
            r_mem[i_req.idx] <= i_req.wdata;
        end
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.idx];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

`default_nettype wire

### design/dcbd_core.sv
// Access decode, control registers, AY register banks and result register.
`default_nettype none

module dcbd_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire dcbd_pkg::t_in_word                i_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [dcbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic [7:0]                        i_ram_rdata,
    output dcbd_pkg::t_ram_req                     o_ram_req,
    output logic                                   o_exec,
    output logic                                   o_done,
    output dcbd_pkg::t_out_word                    o_word
);

    localparam int MAP_W = 14;
    localparam logic [MAP_W-1:0] RAM_LIMIT = MAP_W'(dcbd_pkg::RAM_BYTES);

    typedef struct packed {
        logic             hit;
        logic [MAP_W-1:0] idx;
    } t_map;

    function automatic t_map ram_map(input logic cpu, input logic [15:0] a, input logic wr);
        t_map m;
        m.hit = 1'b0;
        m.idx = '0;
        if (cpu) begin
            if (a[15:12] == 4'h8) begin
                m.hit = 1'b1;
                m.idx = 14'h0d00 + {2'b00, a[11:0]};
            end
        end else if (a[15:11] == 5'b10000) begin
            m.hit = 1'b1;
            m.idx = {3'b000, a[10:0]};
        end else if (a[15:10] == 6'b100010) begin
            m.hit = 1'b1;
            m.idx = 14'h0800 + {4'b0000, a[9:0]};
        end else if (wr && a[15:8] == 8'h90) begin
            m.hit = 1'b1;
            m.idx = 14'h0c00 + {6'b000000, a[7:0]};
        end
        return m;
    endfunction

    dcbd_pkg::t_in_word  r_item;
    logic                r_exec;
    logic                r_rd_ok;
    logic                r_done;
    dcbd_pkg::t_out_word r_out;
    logic [7:0]          r_dip_one;
    logic [7:0]          r_dip_two;
    logic [7:0]          r_sregs [32];
    logic [3:0]          r_ay_sel;
    logic [7:0]          r_sound_cmd;
    logic                r_sound_irq;
    logic                r_nmi_en;
    logic                r_skip_first;
    logic                r_ignore_fire;
    logic                r_bg_mode;
    logic [7:0]          r_filter;

    logic [3:0]          n_ay_sel;
    logic [7:0]          n_sound_cmd;
    logic                n_sound_irq;
    logic                n_nmi_en;
    logic                n_skip_first;
    logic                n_ignore_fire;
    logic                n_bg_mode;
    logic [7:0]          n_filter;
    logic                n_sreg_we;
    logic [4:0]          n_sreg_idx;
    dcbd_pkg::t_out_word n_out;

    t_map                w_rd_map;
    t_map                w_ex_map;
    logic                w_ex_in_range;
    logic [7:0]          w_rd;
    logic                w_rom;
    logic [7:0]          w_port;
    logic [7:0]          w_v;
    logic [15:0]         w_a;
    logic [6:0]          w_btn;
    logic [7:0]          w_joy;

    assign w_rd_map      = ram_map(i_word.cpu, i_word.address, 1'b0);
    assign w_ex_map      = ram_map(r_item.cpu, r_item.address,
                                   r_item.func == dcbd_pkg::FN_MEM_WR);
    assign w_ex_in_range = w_ex_map.idx < RAM_LIMIT;
    assign w_a           = r_item.address;
    assign w_v           = r_item.write_data;
    assign w_btn         = r_item.buttons;
    assign w_port        = r_item.address[7:0];

    always_comb begin
        o_ram_req = '0;
        if (r_exec) begin
            o_ram_req.en    = r_item.func == dcbd_pkg::FN_MEM_WR && w_ex_map.hit
                              && w_ex_in_range;
            o_ram_req.we    = 1'b1;
            o_ram_req.idx   = w_ex_map.idx[dcbd_pkg::RAM_AW-1:0];
            o_ram_req.wdata = w_v;
        end else begin
            o_ram_req.en  = i_accept && i_word.func == dcbd_pkg::FN_MEM_RD
                            && w_rd_map.hit && (w_rd_map.idx < RAM_LIMIT);
            o_ram_req.we  = 1'b0;
            o_ram_req.idx = w_rd_map.idx[dcbd_pkg::RAM_AW-1:0];
        end
    end

    always_comb begin
        n_ay_sel      = r_ay_sel;
        n_sound_cmd   = r_sound_cmd;
        n_sound_irq   = r_sound_irq;
        n_nmi_en      = r_nmi_en;
        n_skip_first  = r_skip_first;
        n_ignore_fire = r_ignore_fire;
        n_bg_mode     = r_bg_mode;
        n_filter      = r_filter;
        n_sreg_we     = 1'b0;
        n_sreg_idx    = {1'b0, r_ay_sel};
        w_rd          = '0;
        w_rom         = 1'b0;
        w_joy         = 8'hff;
        unique case (r_item.func)
            dcbd_pkg::FN_MEM_RD: begin
                if (r_item.cpu) begin
                    if (w_a < 16'h1000) begin
                        w_rom = 1'b1;
                    end else if (w_ex_map.hit) begin
                        w_rd = r_rd_ok ? i_ram_rdata : 8'hff;
                    end else begin
                        w_rd = 8'hff;
                    end
                end else begin
                    priority if (w_a <= 16'h3fff) begin
                        w_rom = 1'b1;
                    end else if (w_ex_map.hit) begin
                        w_rd = r_rd_ok ? i_ram_rdata : 8'hff;
                    end else if (w_a == 16'h9800) begin
                        w_joy[6]      = !w_btn[0];
                        w_joy[5]      = !w_btn[1];
                        w_joy[4]      = !w_btn[2];
                        w_joy[3]      = !w_btn[3];
                        w_joy[2]      = !w_btn[4];
                        n_ignore_fire = r_ignore_fire && w_btn[5];
                        w_joy[0]      = !(!n_ignore_fire && w_btn[5]);
                        w_rd          = w_joy;
                    end else if (w_a == 16'h9801) begin
                        w_rd = r_dip_one;
                    end else if (w_a == 16'h9802) begin
                        w_rd = r_dip_two + {7'd0, !w_btn[6]};
                    end else if (w_a == 16'h9803) begin
                        w_rd = 8'hff;
                    end else if (w_a[15:2] == 14'h2800 || w_a == 16'hb000) begin
                        w_rd = 8'h00;
                    end else begin
                        w_rd = 8'hff;
                    end
                end
            end
            dcbd_pkg::FN_MEM_WR: begin
                if (r_item.cpu) begin
                    if (!w_ex_map.hit && w_a[15:12] == 4'h9) begin
                        n_filter = w_v;
                    end
                end else if (!w_ex_map.hit) begin
                    priority if (w_a == 16'ha000) begin
                        priority if (w_v == 8'h03) begin
                            n_sound_cmd = 8'h06;
                        end else if (w_v == 8'h05) begin
                            n_sound_cmd = 8'h07;
                        end else if (w_v == 8'h0a) begin
                            n_sound_cmd = 8'h0b;
                        end else begin
                            n_sound_cmd = w_v;
                        end
                    end else if (w_a == 16'ha001) begin
                        n_sound_irq = w_v[3];
                    end else if (w_a == 16'ha801) begin
                        if (w_v[0] && r_skip_first) begin
                            n_nmi_en     = 1'b0;
                            n_skip_first = 1'b0;
                        end else begin
                            n_nmi_en = w_v[0];
                        end
                    end else if (w_a == 16'ha803) begin
                        n_bg_mode = w_v[0];
                    end else begin
                        n_bg_mode = r_bg_mode;
                    end
                end
            end
            dcbd_pkg::FN_PORT_OUT: begin
                priority if (w_port == 8'h10 || w_port == 8'h40) begin
                    n_ay_sel = w_v[3:0];
                end else if (w_port == 8'h20) begin
                    n_sreg_we  = 1'b1;
                    n_sreg_idx = {1'b1, r_ay_sel};
                end else if (w_port == 8'h80) begin
                    n_sreg_we  = 1'b1;
                    n_sreg_idx = {1'b0, r_ay_sel};
                end else begin
                    n_sreg_we = 1'b0;
                end
            end
            dcbd_pkg::FN_PORT_IN: begin
                if (w_port == 8'h20 && r_ay_sel < 4'd14) begin
                    w_rd = r_sregs[{1'b1, r_ay_sel}];
                end else if (w_port == 8'h80) begin
                    if (r_ay_sel < 4'd14) begin
                        w_rd = r_sregs[{1'b0, r_ay_sel}];
                    end else if (r_ay_sel == 4'd14) begin
                        w_rd = r_sound_cmd;
                    end
                end
            end
            dcbd_pkg::FN_FETCH: begin
                w_rom = 1'b1;
            end
            dcbd_pkg::FN_IRQ_ACK: begin
                n_sound_irq = 1'b0;
            end
            default: begin
                w_rom = 1'b0;
            end
        endcase
        n_out.read_data         = w_rom ? 8'h00 : w_rd;
        n_out.from_rom          = w_rom;
        n_out.nmi_enabled       = n_nmi_en;
        n_out.sound_irq_pending = n_sound_irq;
        n_out.custom_background = n_bg_mode;
        n_out.sound_filter      = n_filter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec        <= 1'b0;
            r_done        <= 1'b0;
            r_dip_one     <= '0;
            r_dip_two     <= '0;
            r_sregs       <= '{default: '0};
            r_ay_sel      <= '0;
            r_sound_cmd   <= '0;
            r_sound_irq   <= 1'b0;
            r_nmi_en      <= 1'b0;
            r_skip_first  <= 1'b1;
            r_ignore_fire <= 1'b1;
            r_bg_mode     <= 1'b0;
            r_filter      <= '0;
        end else begin
            r_exec <= i_accept;
            r_done <= r_exec;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dcbd_pkg::CFG_DIP_ONE: r_dip_one <= i_cfg_data;
                    dcbd_pkg::CFG_DIP_TWO: r_dip_two <= i_cfg_data;
                    default:               r_dip_one <= r_dip_one;
                endcase
            end
            if (r_exec) begin
                r_ay_sel      <= n_ay_sel;
                r_sound_cmd   <= n_sound_cmd;
                r_sound_irq   <= n_sound_irq;
                r_nmi_en      <= n_nmi_en;
                r_skip_first  <= n_skip_first;
                r_ignore_fire <= n_ignore_fire;
                r_bg_mode     <= n_bg_mode;
                r_filter      <= n_filter;
                if (n_sreg_we) begin
                    r_sregs[n_sreg_idx] <= w_v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item  <= i_word;
            r_rd_ok <= w_rd_map.hit && (w_rd_map.idx < RAM_LIMIT);
        end
        if (r_exec) begin
            r_out <= n_out;
        end
    end

    assign o_exec = r_exec;
    assign o_done = r_done;
    assign o_word = r_out;

endmodule

`default_nettype wire

### design/dual_cpu_bus_decoder_unit.sv
// Top level of the dual CPU bus decoder: handshake, RAM and decode core.
//
// Usage:
//   Present one bus access word on i_word and raise start; the word is taken
//   at a rising edge where start is high and busy is low.
//   The accepted word is registered into r_item with r_exec set; r_exec then
//   sets r_done, and the result word appears on o_word with o_done high for
//   exactly one cycle. The receiver cannot stall; results are never held.
//   For each access the shared RAM is read at the accepting edge, then the
//   access is decoded, state and RAM are written back and the result is
//   registered. busy is high while the access is decoded, so no new access
//   is taken before the last one has been decoded.
//   Configuration: i_cfg_we with i_cfg_idx (0 DIP one, 1 DIP two) and
//   i_cfg_data writes a DIP register at the edge; writes are taken outside reset.
//   Reset (i_rst_n low, synchronous) clears all control state, then the
//   shared RAM is zeroed one byte per cycle over all RAM_BYTES (8192) bytes;
//   busy stays high during reset and that sweep.
`default_nettype none

module dual_cpu_bus_decoder_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire dcbd_pkg::t_in_word                i_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [dcbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [7:0]                        i_cfg_data,
    output logic                                   o_done,
    output dcbd_pkg::t_out_word                    o_word
);

    logic               w_accept;
    logic               w_exec;
    logic               w_ram_ready;
    logic [7:0]         w_ram_rdata;
    dcbd_pkg::t_ram_req w_ram_req;

    assign busy     = w_exec || !w_ram_ready;
    assign w_accept = start && !busy;

    dcbd_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata),
        .o_ready (w_ram_ready)
    );

    dcbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ram_rdata (w_ram_rdata),
        .o_ram_req   (w_ram_req),
        .o_exec      (w_exec),
        .o_done      (o_done),
        .o_word      (o_word)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_done)
        else $error("accepted word produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 2))
        else $error("result without an accepted word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy && !w_ram_req.we == 1'b0)
        else $error("no write-back slot after accept");

endmodule

`default_nettype wire

### test/dcbd_checker.sv
// Checker of the dual CPU bus decoder: tracks accepted words, predicts results, compares them.
`timescale 1ns / 100ps

module dcbd_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire dcbd_pkg::t_in_word             i_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [dcbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_done,
    input  wire dcbd_pkg::t_out_word            i_result,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import dcbd_pkg::*;

    localparam logic [15:0] MAIN_ROM_TOP  = 16'h3fff;
    localparam logic [15:0] SOUND_ROM_END = 16'h1000;
    localparam logic [15:0] ADDR_JOY      = 16'h9800;
    localparam logic [15:0] ADDR_DIP_ONE  = 16'h9801;
    localparam logic [15:0] ADDR_DIP_TWO  = 16'h9802;
    localparam logic [15:0] ADDR_ALL_ONES = 16'h9803;
    localparam logic [15:0] ADDR_SND_CMD  = 16'ha000;
    localparam logic [15:0] ADDR_SND_IRQ  = 16'ha001;
    localparam logic [15:0] ADDR_NMI      = 16'ha801;
    localparam logic [15:0] ADDR_BG       = 16'ha803;
    localparam logic [15:0] ADDR_WATCHDOG = 16'hb000;
    localparam logic [7:0]  PORT_SEL_A    = 8'h10;
    localparam logic [7:0]  PORT_SEL_B    = 8'h40;
    localparam logic [7:0]  PORT_AY_HIGH  = 8'h20;
    localparam logic [7:0]  PORT_AY_LOW   = 8'h80;

    logic [7:0] ram_model [RAM_BYTES];
    logic [7:0] ay_regs [32];
    logic [3:0] ay_sel;
    logic [7:0] sound_cmd_q;
    logic       irq_q;
    logic       nmi_q;
    logic       skip_first_nmi;
    logic       fire_ignored;
    logic       bg_q;
    logic [7:0] filter_q;
    logic [7:0] dip_one_q;
    logic [7:0] dip_two_q;

    t_out_word expected_words [$];

    function automatic logic [7:0] ram_peek(input int unsigned idx);
        return (idx < RAM_BYTES) ? ram_model[idx] : 8'hff;
    endfunction

    function automatic void ram_poke(input int unsigned idx, input logic [7:0] v);
        if (idx < RAM_BYTES) ram_model[idx] = v;
    endfunction

    function automatic logic [7:0] main_read(input logic [15:0] a, input logic [6:0] btn,
                                             output logic rom);
        logic [7:0] r;
        rom = 1'b0;
        r = 8'hff;
        if (a <= MAIN_ROM_TOP) begin
            rom = 1'b1;
            r = 8'h00;
        end else if (a[15:11] == 5'b10000) begin
            r = ram_peek(int'(a) - 'h8000);
        end else if (a >= 16'h8800 && a <= 16'h8bff) begin
            r = ram_peek(int'(a) - 'h8800 + 'h800);
        end else if (a == ADDR_JOY) begin
            if (btn[0]) r[6] = 1'b0;
            if (btn[1]) r[5] = 1'b0;
            if (btn[2]) r[4] = 1'b0;
            if (btn[3]) r[3] = 1'b0;
            if (btn[4]) r[2] = 1'b0;
            if (fire_ignored && !btn[5]) fire_ignored = 1'b0;
            if (!fire_ignored && btn[5]) r[0] = 1'b0;
        end else if (a == ADDR_DIP_ONE) begin
            r = dip_one_q;
        end else if (a == ADDR_DIP_TWO) begin
            r = dip_two_q + (btn[6] ? 8'd0 : 8'd1);
        end else if (a == ADDR_ALL_ONES) begin
            r = 8'hff;
        end else if ((a >= ADDR_SND_CMD && a <= 16'ha003) || a == ADDR_WATCHDOG) begin
            r = 8'h00;
        end
        return r;
    endfunction

    function automatic void main_write(input logic [15:0] a, input logic [7:0] v);
        if (a[15:11] == 5'b10000) begin
            ram_poke(int'(a) - 'h8000, v);
        end else if (a >= 16'h8800 && a <= 16'h8bff) begin
            ram_poke(int'(a) - 'h8800 + 'h800, v);
        end else if (a >= 16'h9000 && a <= 16'h90ff) begin
            ram_poke(int'(a) - 'h9000 + 'hc00, v);
        end else if (a == ADDR_SND_CMD) begin
            case (v)
                8'h03:   sound_cmd_q = 8'h06;
                8'h05:   sound_cmd_q = 8'h07;
                8'h0a:   sound_cmd_q = 8'h0b;
                default: sound_cmd_q = v;
            endcase
        end else if (a == ADDR_SND_IRQ) begin
            irq_q = v[3];
        end else if (a == ADDR_NMI) begin
            nmi_q = v[0];
            if (nmi_q && skip_first_nmi) begin
                nmi_q = 1'b0;
                skip_first_nmi = 1'b0;
            end
        end else if (a == ADDR_BG) begin
            bg_q = v[0];
        end
    endfunction

    function automatic logic [7:0] sound_read(input logic [15:0] a, output logic rom);
        rom = 1'b0;
        if (a < SOUND_ROM_END) begin
            rom = 1'b1;
            return 8'h00;
        end
        if (a[15:12] == 4'h8) return ram_peek(int'(a) - 'h8000 + 'hd00);
        return 8'hff;
    endfunction

    function automatic void sound_write(input logic [15:0] a, input logic [7:0] v);
        if (a[15:12] == 4'h8) ram_poke(int'(a) - 'h8000 + 'hd00, v);
        else if (a[15:12] == 4'h9) filter_q = v;
    endfunction

    function automatic void port_write(input logic [7:0] p, input logic [7:0] v);
        if (p == PORT_SEL_A || p == PORT_SEL_B) ay_sel = v[3:0];
        else if (p == PORT_AY_HIGH) ay_regs[{1'b1, ay_sel}] = v;
        else if (p == PORT_AY_LOW) ay_regs[{1'b0, ay_sel}] = v;
    endfunction

    function automatic logic [7:0] port_read(input logic [7:0] p);
        if (p == PORT_AY_HIGH && ay_sel < 4'd14) return ay_regs[{1'b1, ay_sel}];
        if (p == PORT_AY_LOW) begin
            if (ay_sel < 4'd14) return ay_regs[{1'b0, ay_sel}];
            if (ay_sel == 4'd14) return sound_cmd_q;
        end
        return 8'h00;
    endfunction

    function automatic t_out_word decode_access(input t_in_word w);
        t_out_word r;
        logic [7:0] rd;
        logic       rom;
        rd = 8'h00;
        rom = 1'b0;
        case (w.func)
            FN_MEM_RD: begin
                if (w.cpu) rd = sound_read(w.address, rom);
                else rd = main_read(w.address, w.buttons, rom);
            end
            FN_MEM_WR: begin
                if (w.cpu) sound_write(w.address, w.write_data);
                else main_write(w.address, w.write_data);
            end
            FN_PORT_OUT: port_write(w.address[7:0], w.write_data);
            FN_PORT_IN:  rd = port_read(w.address[7:0]);
            FN_FETCH:    rom = 1'b1;
            FN_IRQ_ACK:  irq_q = 1'b0;
            default: ;
        endcase
        if (rom) rd = 8'h00;
        r.read_data         = rd;
        r.from_rom          = rom;
        r.nmi_enabled       = nmi_q;
        r.sound_irq_pending = irq_q;
        r.custom_background = bg_q;
        r.sound_filter      = filter_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < RAM_BYTES; i++) ram_model[i] = 8'h00;
            for (int i = 0; i < 32; i++) ay_regs[i] = 8'h00;
            ay_sel = 4'd0;
            sound_cmd_q = 8'h00;
            irq_q = 1'b0;
            nmi_q = 1'b0;
            skip_first_nmi = 1'b1;
            fire_ignored = 1'b1;
            bg_q = 1'b0;
            filter_q = 8'h00;
            dip_one_q = 8'h00;
            dip_two_q = 8'h00;
            expected_words.delete();
        end else begin
            if (i_done) begin
                if (expected_words.size() == 0) begin
                    $display("%0t result word: expected none actual %h", $time, i_result);
                    o_mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("read_data", want.read_data, i_result.read_data);
                    check_field("from_rom", 8'(want.from_rom), 8'(i_result.from_rom));
                    check_field("nmi_enabled", 8'(want.nmi_enabled), 8'(i_result.nmi_enabled));
                    check_field("sound_irq_pending", 8'(want.sound_irq_pending),
                                8'(i_result.sound_irq_pending));
                    check_field("custom_background", 8'(want.custom_background),
                                8'(i_result.custom_background));
                    check_field("sound_filter", want.sound_filter, i_result.sound_filter);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIP_ONE) dip_one_q = i_cfg_data;
                else if (i_cfg_idx == CFG_DIP_TWO) dip_two_q = i_cfg_data;
            end
            if (i_start && !i_busy) expected_words.push_back(decode_access(i_word));
        end
        o_pending = expected_words.size();
    end

endmodule

### test/tb.sv
// Testbench top of the dual CPU bus decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import dcbd_pkg::*;

    localparam int IDLE_LIMIT   = 40000;
    localparam int RANDOM_WORDS = 1600;
    localparam int MAX_GAP      = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_word             i_word;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;
    logic                 o_done;
    t_out_word            o_word;

    int mismatches;
    int pending;
    int idle_pct;
    int stall_cycles;

    dual_cpu_bus_decoder_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_word     (o_word)
    );

    dcbd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_word       (i_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_result     (o_word),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("dual_cpu_bus_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    function automatic t_in_word access(input logic c, input t_func f, input logic [15:0] a,
                                        input logic [7:0] d, input logic [6:0] b);
        t_in_word w;
        w.cpu        = c;
        w.func       = f;
        w.address    = a;
        w.write_data = d;
        w.buttons    = b;
        return w;
    endfunction

    function automatic logic [15:0] near_offset(input int unsigned span);
        if ($urandom_range(3) == 0) return 16'($urandom_range(span));
        return 16'($urandom_range(15));
    endfunction

    function automatic logic [15:0] pick_address(input logic c, input logic is_port);
        logic [15:0] regs [9];
        logic [15:0] edges_main [11];
        logic [15:0] edges_sound [6];
        logic [7:0]  ports [4];
        regs        = '{16'ha000, 16'ha001, 16'ha002, 16'ha003, 16'ha800,
                        16'ha801, 16'ha802, 16'ha803, 16'hb000};
        edges_main  = '{16'h3fff, 16'h4000, 16'h7fff, 16'h87ff, 16'h8c00, 16'h8fff,
                        16'h9100, 16'h97ff, 16'h9804, 16'hb001, 16'hffff};
        edges_sound = '{16'h0fff, 16'h1000, 16'h7fff, 16'h8fff, 16'h9fff, 16'ha000};
        ports       = '{8'h10, 8'h20, 8'h40, 8'h80};
        if (is_port) begin
            if ($urandom_range(4) == 0) return 16'($urandom);
            return {8'($urandom), ports[$urandom_range(3)]};
        end
        case ($urandom_range(7))
            0: return 16'($urandom);
            1: return c ? 16'($urandom_range(16'h0fff)) : 16'($urandom_range(16'h3fff));
            2: return c ? 16'h8000 + near_offset(16'h0fff) : 16'h8000 + near_offset(16'h07ff);
            3: return c ? 16'h8000 + near_offset(16'h0fff) : 16'h8800 + near_offset(16'h03ff);
            4: return c ? 16'h9000 + 16'($urandom_range(16'h0fff))
                        : 16'h9000 + near_offset(16'h00ff);
            5: return c ? 16'h8000 + near_offset(16'h0fff) : 16'h9800 + 16'($urandom_range(3));
            6: return regs[$urandom_range(8)];
            default: return c ? edges_sound[$urandom_range(5)] : edges_main[$urandom_range(10)];
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        logic [7:0]  specials [7];
        specials = '{8'h03, 8'h05, 8'h0a, 8'h00, 8'hff, 8'h08, 8'h01};
        pick = $urandom_range(99);
        w.cpu = 1'($urandom);
        if (pick < 30) w.func = FN_MEM_RD;
        else if (pick < 55) w.func = FN_MEM_WR;
        else if (pick < 70) w.func = FN_PORT_OUT;
        else if (pick < 85) w.func = FN_PORT_IN;
        else if (pick < 90) w.func = FN_FETCH;
        else if (pick < 95) w.func = FN_IRQ_ACK;
        else w.func = t_func'(pick[0] ? 3'd6 : 3'd7);
        w.address = pick_address(w.cpu, w.func == FN_PORT_OUT || w.func == FN_PORT_IN);
        w.write_data = ($urandom_range(3) == 0) ? specials[$urandom_range(6)] : 8'($urandom);
        w.buttons = 7'($urandom);
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_word <= w;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_dips(input logic [7:0] one, input logic [7:0] two);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIP_ONE;
        i_cfg_data <= one;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DIP_TWO;
        i_cfg_data <= two;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_word     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_DIP_ONE;
        i_cfg_data = 8'h00;
        idle_pct   = 33;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // DIP values straight out of reset
        send_word(access(1'b0, FN_MEM_RD, 16'h9801, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_RD, 16'h9802, 8'h00, 7'h00));
        drain_results();
        write_dips(8'hff, 8'hff);

        send_word(access(1'b0, FN_MEM_RD, 16'h9802, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_RD, 16'h9800, 8'h00, 7'h7f));
        send_word(access(1'b0, FN_MEM_RD, 16'h9800, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_RD, 16'h9800, 8'h00, 7'h3f));
        send_word(access(1'b0, FN_MEM_WR, 16'h8bff, 8'hff, 7'h00));
        send_word(access(1'b0, FN_MEM_RD, 16'h8bff, 8'h00, 7'h00));
        send_word(access(1'b1, FN_MEM_WR, 16'h8fff, 8'ha5, 7'h00));
        send_word(access(1'b1, FN_MEM_RD, 16'h8fff, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'h90ff, 8'h77, 7'h00));
        send_word(access(1'b0, FN_MEM_RD, 16'h3fff, 8'h00, 7'h00));
        send_word(access(1'b1, FN_MEM_RD, 16'h1000, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha000, 8'h03, 7'h00));
        send_word(access(1'b1, FN_PORT_OUT, 16'h0010, 8'h0e, 7'h00));
        send_word(access(1'b1, FN_PORT_IN, 16'h0080, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha000, 8'h05, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha001, 8'h08, 7'h00));
        send_word(access(1'b1, FN_IRQ_ACK, 16'h0000, 8'h00, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha801, 8'h01, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha801, 8'hff, 7'h00));
        send_word(access(1'b0, FN_MEM_WR, 16'ha803, 8'hff, 7'h00));
        send_word(access(1'b1, FN_MEM_WR, 16'h9000, 8'hff, 7'h00));
        send_word(access(1'b0, FN_PORT_OUT, 16'h0040, 8'h0d, 7'h00));
        send_word(access(1'b0, FN_PORT_OUT, 16'h0020, 8'haa, 7'h00));
        send_word(access(1'b0, FN_PORT_IN, 16'h0020, 8'h00, 7'h00));
        send_word(access(1'b0, FN_PORT_OUT, 16'hff10, 8'h0f, 7'h00));
        send_word(access(1'b0, FN_PORT_IN, 16'h0080, 8'h00, 7'h00));
        send_word(access(1'b1, FN_FETCH, 16'hffff, 8'hff, 7'h7f));
        send_word(access(1'b1, t_func'(3'd7), 16'hffff, 8'hff, 7'h7f));

        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_dips(8'h00, 8'h00);
                    idle_pct = 33;
                end
                1: begin
                    write_dips(8'($urandom), 8'hff);
                    idle_pct = 62;
                end
                default: begin
                    write_dips(8'hff, 8'($urandom));
                    idle_pct = 0;
                end
            endcase
            repeat (RANDOM_WORDS / 3) send_word(random_word());
        end
        drain_results();

        if (mismatches == 0 && pending == 0) begin
            $display("dual_cpu_bus_decoder_unit: match");
        end else begin
            $display("dual_cpu_bus_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
